### hw/rtl/bsk_pkg.sv
// package for the battery charge kalman filter: types, constants, arithmetic helpers
package bsk_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 41;

    localparam logic [REG_IDX_W-1:0] REG_RC_DECAY = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COULOMB = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RC_RES = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SER_RES = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHG_NOISE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RC_NOISE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MEAS_NOISE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SOC_MAX = 3'd7;

    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_PREDICT = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_DSOC, ST_P_DRIVE, ST_P_RCA, ST_P_DRB, ST_P_CU, ST_P_CL, ST_P_AP, ST_P_CR,
        ST_U_DROP, ST_U_SUM, ST_U_DIV1, ST_U_DIV2, ST_U_K1Y, ST_U_K2Y,
        ST_U_M1, ST_U_M2, ST_U_M3, ST_U_M4, ST_U_M5, ST_U_M6, ST_U_M7, ST_U_M8,
        ST_DONE
    } state_t;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MS_DSOC, MS_DRIVE, MS_RCA, MS_DRB, MS_CU, MS_CL, MS_AP, MS_CR, MS_DROP,
        MS_K1Y, MS_K2Y, MS_C1P11, MS_K1P21, MS_C1P12, MS_K1P22, MS_C2P21
    } msel_t;

    // where the finished product goes
    typedef enum logic [3:0] {
        WB_NONE, WB_CHG, WB_T1, WB_T2, WB_VRC_DRB, WB_P12, WB_P21, WB_P22,
        WB_VRC_ADD, WB_T1_ACC, WB_T2_ACC, WB_S, WB_K1, WB_COV
    } wb_t;

    typedef struct packed {
        logic load_in;
        logic do_init;
        logic mul_go;
        msel_t msel;
        wb_t wb;
        logic sum_s;
        logic div_go;
        logic div_second;
        logic k1k2_extra;    // k1*p22, c2*p22 and k2*p12 products, selected via msel
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic [1:0] mode;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7fffffff;
        if (v < -36'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] cap(input logic neg, input logic [63:0] m);
        logic [31:0] c;
        if (neg) c = (m > 64'h80000000) ? 32'h80000000 : m[31:0];
        else c = (m > 64'h7fffffff) ? 32'h7fffffff : m[31:0];
        return neg ? -$signed(c) : $signed(c);
    endfunction

endpackage

### hw/rtl/battery_soc_kalman_filter_unit.sv
// top level of the battery charge kalman filter
//  channel  | handshake             | payload
//  in       | in_valid / in_ready   | mode, cell_current, measured_voltage, start_soc
//  out      | out_valid / out_ready | soc_estimate, rc_voltage, predicted_voltage, innovation
//  cfg      | cfg_we                | cfg_index, cfg_data
// init and the unused mode give their result straight from idle; predict runs eight passes
// of the shared multiplier; update runs its own passes of the shared multiplier
// and two passes of the 59-step gain divider
// reset clears control and loads the state and register reset values
// a stalled result holds the block; the next item is taken once it is delivered
module battery_soc_kalman_filter_unit #(
    parameter int FRAC_BITS = bsk_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic signed [31:0]             cell_current,
    input  logic signed [31:0]             measured_voltage,
    input  logic signed [31:0]             start_soc,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [24:0]                    soc_estimate,
    output logic signed [31:0]             rc_voltage,
    output logic signed [31:0]             predicted_voltage,
    output logic signed [31:0]             innovation,
    input  logic                           cfg_we,
    input  logic [bsk_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [bsk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsk_pkg::*;
    cmd_t cmd;
    status_t status;

    bsk_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .mode(mode), .status(status), .cmd(cmd));

    bsk_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd),
        .status(status), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mode(mode), .cell_current(cell_current), .measured_voltage(measured_voltage),
        .start_soc(start_soc), .soc_estimate(soc_estimate), .rc_voltage(rc_voltage),
        .predicted_voltage(predicted_voltage), .innovation(innovation));
endmodule

### hw/rtl/bsk_mul.sv
// sequential magnitude multiplier with rounding shift and saturation
module bsk_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [41:0] a,
    input  logic signed [41:0] b,
    input  logic [5:0]         sh,
    output logic               done,
    output logic signed [31:0] p
);
    import bsk_pkg::*;
    // a is up to 42 bits, b is 32 bits of magnitude: two 21x32 partials
    logic [41:0] ua_reg, ua_next;
    logic [31:0] ub_reg, ub_next;
    logic [73:0] acc_reg, acc_next;
    logic neg_reg, neg_next;
    logic [5:0] sh_reg, sh_next;
    logic [1:0] ph_reg, ph_next;
    logic signed [31:0] p_reg, p_next;
    logic [73:0] rnd, q;
    logic [20:0] part;
    logic [52:0] pp;

    always_comb
    begin
        ua_next = ua_reg; ub_next = ub_reg; acc_next = acc_reg; neg_next = neg_reg;
        sh_next = sh_reg; ph_next = 2'd0; p_next = p_reg;
        rnd = acc_reg + (74'd1 << (sh_reg - 6'd1));
        q = rnd >> sh_reg;
        part = (ph_reg == 2'd1) ? ua_reg[20:0] : ua_reg[41:21];
        pp = part * ub_reg;
        if (go)
        begin
            ua_next = a[41] ? 42'(-a) : 42'(a);
            ub_next = b[41] ? 32'(-b) : 32'(b);
            neg_next = a[41] ^ b[41];
            sh_next = sh;
            acc_next = '0;
            ph_next = 2'd1;
        end
        else if (ph_reg == 2'd1)
        begin
            acc_next = 74'(pp);
            ph_next = 2'd2;
        end
        else if (ph_reg == 2'd2)
        begin
            acc_next = acc_reg + (74'(pp) << 21);
            ph_next = 2'd3;
        end
        else if (ph_reg == 2'd3)
        begin
            p_next = cap(neg_reg, (q[73:64] != 0) ? 64'hffffffffffffffff : q[63:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= 2'd0;
        else
            ph_reg <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        ua_reg <= ua_next; ub_reg <= ub_next; acc_reg <= acc_next;
        neg_reg <= neg_next; sh_reg <= sh_next; p_reg <= p_next;
    end

    assign done = (ph_reg == 2'd3);
    assign p = p_next;
endmodule

### hw/rtl/bsk_div.sv
// radix-2 restoring divider for the gain, rounded half away from zero
module bsk_div #(
    parameter int FRAC_BITS = bsk_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [34:0] n,
    input  logic signed [31:0] d,
    output logic               done,
    output logic signed [31:0] q
);
    import bsk_pkg::*;
    localparam int NW = 35 + FRAC_BITS;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [30:0] d_reg, d_next;
    logic neg_reg, neg_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [32:0] trial;
    logic [NW-1:0] un;

    always_comb
    begin
        num_next = num_reg; quo_next = quo_reg; rem_next = rem_reg; d_next = d_reg;
        neg_next = neg_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        un = n[34] ? NW'($unsigned(-n)) : NW'($unsigned(n));
        trial = {rem_reg[31:0], num_reg[NW-1]};
        if (go)
        begin
            // numerator (|n| << frac) + d/2 folded in as rounding term
            num_next = (un << FRAC_BITS) + NW'(d[30:1]);
            d_next = d[30:0];
            neg_next = n[34];
            rem_next = '0; quo_next = '0;
            cnt_next = 7'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (trial >= {2'b0, d_reg})
            begin
                rem_next = trial - {2'b0, d_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next; quo_reg <= quo_next; rem_reg <= rem_next;
        d_reg <= d_next; neg_reg <= neg_next;
    end

    assign done = busy_reg && (cnt_reg == 7'd1);
    assign q = cap(neg_reg, 64'(quo_next));
endmodule

### hw/rtl/bsk_datapath.sv
// state registers, configuration registers and the shared multiplier and divider
module bsk_datapath #(
    parameter int FRAC_BITS = bsk_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsk_pkg::cmd_t                     cmd,
    output bsk_pkg::status_t                  status,
    input  logic                              cfg_we,
    input  logic [bsk_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [bsk_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [1:0]                        mode,
    input  logic signed [31:0]                cell_current,
    input  logic signed [31:0]                measured_voltage,
    input  logic signed [31:0]                start_soc,
    output logic [24:0]                       soc_estimate,
    output logic signed [31:0]                rc_voltage,
    output logic signed [31:0]                predicted_voltage,
    output logic signed [31:0]                innovation
);
    import bsk_pkg::*;
    localparam logic signed [35:0] ONE_Q = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0] OCV = 36'(((64'sd32 <<< FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] COV0 = 32'(((64'sd1 <<< FRAC_BITS) + 50) / 100);

    logic [24:0] decay_reg, cnoise_reg, rnoise_reg, mnoise_reg, smax_reg;
    logic [40:0] cgain_reg;
    logic [30:0] r1_reg, r0_reg;
    logic signed [31:0] chg_reg, vrc_reg, p11_reg, p12_reg, p21_reg, p22_reg;
    logic signed [31:0] lp_reg, li_reg;
    logic [1:0] mode_reg;
    logic signed [31:0] cur_reg, vm_reg;
    logic signed [31:0] t1_reg, t2_reg, s_reg, k1_reg, k2_reg;

    logic signed [41:0] ma, mb;
    logic [5:0] msh;
    logic signed [31:0] mp, dq;
    logic mdone, ddone;
    logic signed [34:0] dn;
    logic signed [31:0] curmag;

    function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                                 input logic [24:0] mx);
        if (v < 0) return '0;
        if (v > $signed({7'd0, mx})) return $signed({7'd0, mx});
        return v;
    endfunction

    assign curmag = cur_reg[31] ? -cur_reg : cur_reg;

    always_comb
    begin
        ma = '0; mb = '0; msh = 6'(FRAC_BITS);
        unique case (cmd.msel)
            // the 41-bit gain goes on the wide operand
            MS_DSOC:  begin ma = 42'($signed({1'b0, cgain_reg})); mb = 42'(cur_reg);
                            msh = 6'(56 - FRAC_BITS); end
            MS_DRIVE: begin ma = 42'($signed({1'b0, curmag}));
                            mb = 42'($signed({1'b0, r1_reg})); msh = 6'd16; end
            MS_RCA:   begin ma = 42'(vrc_reg); mb = 42'($signed({1'b0, decay_reg})); end
            MS_DRB:   begin ma = 42'(t1_reg); mb = 42'(ONE_Q - $signed({11'd0, decay_reg})); end
            MS_CU:    begin ma = 42'(p12_reg); mb = 42'($signed({1'b0, decay_reg})); end
            MS_CL:    begin ma = 42'(p21_reg); mb = 42'($signed({1'b0, decay_reg})); end
            MS_AP:    begin ma = 42'(p22_reg); mb = 42'($signed({1'b0, decay_reg})); end
            MS_CR:    begin ma = 42'(t1_reg); mb = 42'($signed({1'b0, decay_reg})); end
            MS_DROP:  begin ma = 42'($signed({1'b0, curmag}));
                            mb = 42'($signed({1'b0, r0_reg})); msh = 6'd16; end
            MS_K1Y:   begin ma = 42'(k1_reg); mb = 42'(li_reg); end
            MS_K2Y:   begin ma = 42'(k2_reg); mb = 42'(li_reg); end
            MS_C1P11: begin ma = 42'(ONE_Q - 36'(k1_reg)); mb = 42'(p11_reg); end
            MS_K1P21: begin ma = 42'(k1_reg); mb = 42'(cmd.k1k2_extra ? p22_reg : p21_reg); end
            MS_C1P12: begin ma = 42'(ONE_Q - 36'(k1_reg)); mb = 42'(p12_reg); end
            MS_K1P22: begin ma = 42'(k2_reg); mb = 42'(cmd.k1k2_extra ? p12_reg : p11_reg); end
            MS_C2P21: begin ma = 42'(ONE_Q + 36'(k2_reg));
                            mb = 42'(cmd.k1k2_extra ? p22_reg : p21_reg); end
            default:  begin ma = '0; mb = '0; end
        endcase
    end

    bsk_mul u_mul (.clk(clk), .rst_n(rst_n), .go(cmd.mul_go), .a(ma), .b(mb), .sh(msh),
                   .done(mdone), .p(mp));

    assign dn = cmd.div_second ? (35'(p21_reg) - 35'(p22_reg)) : (35'(p11_reg) - 35'(p12_reg));
    bsk_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .rst_n(rst_n), .go(cmd.div_go),
                   .n(dn), .d(s_reg), .done(ddone), .q(dq));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= '0; cgain_reg <= '0; r1_reg <= '0; r0_reg <= '0;
            cnoise_reg <= 25'd1678; rnoise_reg <= 25'd16777; mnoise_reg <= 25'd167772;
            smax_reg <= 25'd16777216;
            chg_reg <= '0; vrc_reg <= '0; p11_reg <= COV0; p12_reg <= '0; p21_reg <= '0;
            p22_reg <= COV0; lp_reg <= '0; li_reg <= '0;
            t1_reg <= '0; t2_reg <= '0; s_reg <= '0; k1_reg <= '0; k2_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RC_DECAY:   decay_reg <= cfg_data[24:0];
                    REG_COULOMB:    cgain_reg <= cfg_data[40:0];
                    REG_RC_RES:     r1_reg <= cfg_data[30:0];
                    REG_SER_RES:    r0_reg <= cfg_data[30:0];
                    REG_CHG_NOISE:  cnoise_reg <= cfg_data[24:0];
                    REG_RC_NOISE:   rnoise_reg <= cfg_data[24:0];
                    REG_MEAS_NOISE: mnoise_reg <= cfg_data[24:0];
                    REG_SOC_MAX:    smax_reg <= cfg_data[24:0];
                    default: ;
                endcase
            end
            if (cmd.do_init)
            begin
                chg_reg <= clamp(start_soc, smax_reg);
                vrc_reg <= '0; p11_reg <= COV0; p12_reg <= '0; p21_reg <= '0;
                p22_reg <= COV0; lp_reg <= '0; li_reg <= '0;
            end
            if (cmd.sum_s)
            begin
                // prediction and innovation
                lp_reg <= sat32(OCV + 36'(clamp(chg_reg, smax_reg)) - 36'(vrc_reg)
                                - 36'(t1_reg));
                li_reg <= sat32(36'(vm_reg) - 36'(sat32(OCV + 36'(clamp(chg_reg, smax_reg))
                                - 36'(vrc_reg) - 36'(t1_reg))));
            end
            if (mdone)
            begin
                unique case (cmd.wb)
                    WB_CHG: chg_reg <= clamp(sat32(36'(chg_reg) + 36'(mp)), smax_reg);
                    WB_T1: t1_reg <= mp;
                    WB_T2: t2_reg <= mp;
                    WB_VRC_DRB: vrc_reg <= sat32(36'(t2_reg) + 36'(mp));
                    WB_P12: p12_reg <= mp;
                    WB_P21:
                    begin
                        p21_reg <= mp;
                        p11_reg <= sat32(36'(p11_reg) + 36'($signed({1'b0, cnoise_reg})));
                    end
                    WB_P22: p22_reg <= sat32(36'(mp) + 36'($signed({1'b0, rnoise_reg})));
                    WB_VRC_ADD: vrc_reg <= sat32(36'(vrc_reg) + 36'(mp));
                    WB_T1_ACC: t1_reg <= sat32(36'(t1_reg) + 36'(mp));
                    WB_T2_ACC: t2_reg <= sat32(36'(t2_reg) + 36'(mp));
                    WB_S: s_reg <= mp;
                    WB_K1: k1_reg <= sat32(36'(s_reg) - 36'(mp));
                    WB_COV:
                    begin
                        p11_reg <= t1_reg; p12_reg <= t2_reg; p21_reg <= k1_reg;
                        p22_reg <= sat32(36'(s_reg) - 36'(mp));
                    end
                    default: ;
                endcase
            end
            if (ddone)
            begin
                if (cmd.div_second) k2_reg <= dq;
                else k1_reg <= dq;
            end
            // innovation variance, floored at one lsb
            if (cmd.sum_s)
            begin
                if (sat32(36'(p11_reg) - 36'(p12_reg) - 36'(p21_reg) + 36'(p22_reg)
                          + 36'($signed({1'b0, mnoise_reg}))) < 32'sd1)
                    s_reg <= 32'sd1;
                else
                    s_reg <= sat32(36'(p11_reg) - 36'(p12_reg) - 36'(p21_reg) + 36'(p22_reg)
                                   + 36'($signed({1'b0, mnoise_reg})));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode; cur_reg <= cell_current; vm_reg <= measured_voltage;
        end
    end

    assign status.mul_done = mdone;
    assign status.div_done = ddone;
    assign status.mode = mode_reg;
    assign soc_estimate = chg_reg[24:0];
    assign rc_voltage = vrc_reg;
    assign predicted_voltage = lp_reg;
    assign innovation = li_reg;
endmodule

### hw/rtl/bsk_ctrl.sv
// sequencer for init, predict and update steps
module bsk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic [1:0]       mode,
    input  bsk_pkg::status_t status,
    output bsk_pkg::cmd_t    cmd
);
    import bsk_pkg::*;
    state_t st_reg, st_next;
    logic go_reg, go_next;
    logic ov_reg, ov_next;
    logic acc;

    assign in_ready = (st_reg == ST_IDLE) && !ov_reg;
    assign acc = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        st_next = st_reg;
        go_next = 1'b0;
        ov_next = ov_reg && !out_ready;
        unique case (st_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (mode == MODE_PREDICT) begin st_next = ST_P_DSOC; go_next = 1'b1; end
                    else if (mode == MODE_UPDATE) begin st_next = ST_U_DROP; go_next = 1'b1; end
                    else ov_next = 1'b1;
                end
            ST_U_SUM: begin st_next = ST_U_DIV1; go_next = 1'b1; end
            ST_U_DIV1: if (status.div_done) begin st_next = ST_U_DIV2; go_next = 1'b1; end
            ST_U_DIV2: if (status.div_done) begin st_next = ST_U_K1Y; go_next = 1'b1; end
            ST_DONE: begin st_next = ST_IDLE; ov_next = 1'b1; end
            default:
                if (status.mul_done)
                begin
                    go_next = 1'b1;
                    unique case (st_reg)
                        ST_P_DSOC: st_next = ST_P_DRIVE;
                        ST_P_DRIVE: st_next = ST_P_RCA;
                        ST_P_RCA: st_next = ST_P_DRB;
                        ST_P_DRB: st_next = ST_P_CU;
                        ST_P_CU: st_next = ST_P_CL;
                        ST_P_CL: st_next = ST_P_AP;
                        ST_P_AP: st_next = ST_P_CR;
                        ST_U_DROP: begin st_next = ST_U_SUM; go_next = 1'b0; end
                        ST_U_K1Y: st_next = ST_U_K2Y;
                        ST_U_K2Y: st_next = ST_U_M1;
                        ST_U_M1: st_next = ST_U_M2;
                        ST_U_M2: st_next = ST_U_M3;
                        ST_U_M3: st_next = ST_U_M4;
                        ST_U_M4: st_next = ST_U_M5;
                        ST_U_M5: st_next = ST_U_M6;
                        ST_U_M6: st_next = ST_U_M7;
                        ST_U_M7: st_next = ST_U_M8;
                        default: begin st_next = ST_DONE; go_next = 1'b0; end
                    endcase
                end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.load_in = acc;
        cmd.do_init = acc && (mode == MODE_INIT);
        cmd.msel = MS_DSOC;
        cmd.div_go = go_reg && (st_reg == ST_U_DIV1 || st_reg == ST_U_DIV2);
        cmd.mul_go = go_reg && !cmd.div_go;
        cmd.sum_s = (st_reg == ST_U_SUM);
        cmd.div_second = (st_reg == ST_U_DIV2);
        unique case (st_reg)
            ST_P_DSOC:  begin cmd.msel = MS_DSOC; cmd.wb = WB_CHG; end
            ST_P_DRIVE: begin cmd.msel = MS_DRIVE; cmd.wb = WB_T1; end
            ST_P_RCA:   begin cmd.msel = MS_RCA; cmd.wb = WB_T2; end
            ST_P_DRB:   begin cmd.msel = MS_DRB; cmd.wb = WB_VRC_DRB; end
            ST_P_CU:    begin cmd.msel = MS_CU; cmd.wb = WB_P12; end
            ST_P_CL:    begin cmd.msel = MS_CL; cmd.wb = WB_P21; end
            ST_P_AP:    begin cmd.msel = MS_AP; cmd.wb = WB_T1; end
            ST_P_CR:    begin cmd.msel = MS_CR; cmd.wb = WB_P22; end
            ST_U_DROP:  begin cmd.msel = MS_DROP; cmd.wb = WB_T1; end
            ST_U_K1Y:   begin cmd.msel = MS_K1Y; cmd.wb = WB_CHG; end
            ST_U_K2Y:   begin cmd.msel = MS_K2Y; cmd.wb = WB_VRC_ADD; end
            ST_U_M1:    begin cmd.msel = MS_C1P11; cmd.wb = WB_T1; end
            ST_U_M2:    begin cmd.msel = MS_K1P21; cmd.wb = WB_T1_ACC; end
            ST_U_M3:    begin cmd.msel = MS_C1P12; cmd.wb = WB_T2; end
            ST_U_M4:    begin cmd.msel = MS_K1P21; cmd.k1k2_extra = 1'b1; cmd.wb = WB_T2_ACC; end
            ST_U_M5:    begin cmd.msel = MS_C2P21; cmd.wb = WB_S; end
            ST_U_M6:    begin cmd.msel = MS_K1P22; cmd.wb = WB_K1; end
            ST_U_M7:    begin cmd.msel = MS_C2P21; cmd.k1k2_extra = 1'b1; cmd.wb = WB_S; end
            ST_U_M8:    begin cmd.msel = MS_K1P22; cmd.k1k2_extra = 1'b1; cmd.wb = WB_COV; end
            default:    begin cmd.msel = MS_DSOC; cmd.wb = WB_NONE; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; go_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; go_reg <= go_next; ov_reg <= ov_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) acc |-> !ov_reg)
        else $error("item taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !in_ready)
        else $error("ready while busy");
endmodule
